>>> rtl/acri_pkg.sv
// Shared types, constants and the write-sequence decoder for the ATA read command issue block.
// Used by ata_read_command_issue, acri_cache and acri_checker; depends on nothing else.
`timescale 1ns / 1ps

package acri_pkg;

  // default depth of the per-bus drive select cache
  localparam int unsigned CACHE_ENTRIES_DEF = 4;

  // task-file register offsets from the bus base port
  localparam logic [2:0] OFS_COUNT   = 3'd2;
  localparam logic [2:0] OFS_LBA_LO  = 3'd3;
  localparam logic [2:0] OFS_LBA_MID = 3'd4;
  localparam logic [2:0] OFS_LBA_HI  = 3'd5;
  localparam logic [2:0] OFS_SELECT  = 3'd6;
  localparam logic [2:0] OFS_CMD     = 3'd7;

  // drive select base bytes and command opcodes
  localparam logic [7:0] SEL_LBA48    = 8'hE0;
  localparam logic [7:0] SEL_LBA28    = 8'h40;
  localparam logic [7:0] CMD_READ_EXT = 8'h24;
  localparam logic [7:0] CMD_READ     = 8'h20;

  // result kinds
  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_EMPTY  = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  // positions in the register write sequence; lba28 runs select, then count low onward
  typedef enum logic [3:0] {
    S_SELECT = 4'd0,
    S_CNT_HI = 4'd1,
    S_LBA_3  = 4'd2,
    S_LBA_4  = 4'd3,
    S_LBA_5  = 4'd4,
    S_CNT_LO = 4'd5,
    S_LBA_0  = 4'd6,
    S_LBA_1  = 4'd7,
    S_LBA_2  = 4'd8,
    S_CMD    = 4'd9
  } step_e;

  // lookup request to the select cache
  typedef struct packed {
    logic        start;
    logic [15:0] port;
    logic        dev;
    logic [7:0]  sel;
  } cache_req_t;

  // lookup answer from the select cache
  typedef struct packed {
    logic done;
    logic needed;
  } cache_rsp_t;

  // one register write word before the base port is added
  typedef struct packed {
    logic [2:0] ofs;
    logic [7:0] data;
    logic       last;
  } word_t;

  // register offset and byte for one sequence position
  function automatic word_t acri_word(logic mode, step_e step, logic [15:0] cnt,
                                     logic [47:0] lba, logic [7:0] sel);
    word_t w;
    w.ofs  = OFS_CMD;
    w.data = 8'h00;
    w.last = 1'b0;
    unique case (step)
      S_SELECT: begin w.ofs = OFS_SELECT;  w.data = sel;          end
      S_CNT_HI: begin w.ofs = OFS_COUNT;   w.data = cnt[15:8];    end
      S_LBA_3:  begin w.ofs = OFS_LBA_LO;  w.data = lba[31:24];   end
      S_LBA_4:  begin w.ofs = OFS_LBA_MID; w.data = lba[39:32];   end
      S_LBA_5:  begin w.ofs = OFS_LBA_HI;  w.data = lba[47:40];   end
      S_CNT_LO: begin w.ofs = OFS_COUNT;   w.data = cnt[7:0];     end
      S_LBA_0:  begin w.ofs = OFS_LBA_LO;  w.data = lba[7:0];     end
      S_LBA_1:  begin w.ofs = OFS_LBA_MID; w.data = lba[15:8];    end
      S_LBA_2:  begin w.ofs = OFS_LBA_HI;  w.data = lba[23:16];   end
      S_CMD: begin
        w.ofs  = OFS_CMD;
        w.data = mode ? CMD_READ_EXT : CMD_READ;
        w.last = 1'b1;
      end
      default: begin
        w.ofs  = OFS_CMD;
        w.data = 8'h00;
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/acri_cache.sv
// Per-bus drive select cache with a single shared compare unit scanning one entry per cycle.
// Depends on acri_pkg for the request and answer structs.
`timescale 1ns / 1ps

module acri_cache #(
  parameter int unsigned ENTRIES = acri_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  acri_pkg::cache_req_t   req_i,
  output acri_pkg::cache_rsp_t   rsp_o
);
  import acri_pkg::*;

  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [15:0]     port_q [ENTRIES];
  logic            dev_q  [ENTRIES];
  logic [7:0]      sel_q  [ENTRIES];

  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            busy_q, busy_d;
  logic [15:0]     rport_q;
  logic            rdev_q;
  logic [7:0]      rsel_q;

  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  logic            hit;
  logic [IdxW-1:0] rd_idx;

  assign rd_idx = idx_q[IdxW-1:0];
  assign hit    = (port_q[rd_idx] == rport_q);

  // scan step: end of filled entries, a match, or move on
  always_comb begin
    fill_d       = fill_q;
    idx_d        = idx_q;
    busy_d       = busy_q;
    wr_en        = 1'b0;
    wr_idx       = rd_idx;
    rsp_o.done   = 1'b0;
    rsp_o.needed = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (busy_q) begin
      if (idx_q == fill_q) begin
        rsp_o.done   = 1'b1;
        rsp_o.needed = 1'b1;
        busy_d       = 1'b0;
        if (fill_q != CntW'(ENTRIES)) begin
          wr_en  = 1'b1;
          wr_idx = fill_q[IdxW-1:0];
          fill_d = fill_q + 1'b1;
        end
      end else if (hit) begin
        rsp_o.done   = 1'b1;
        rsp_o.needed = !((dev_q[rd_idx] == rdev_q) && (sel_q[rd_idx] == rsel_q));
        busy_d       = 1'b0;
        wr_en        = rsp_o.needed;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      idx_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      idx_q  <= idx_d;
      busy_q <= busy_d;
    end
  end

  // request capture and entry storage
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rport_q <= req_i.port;
      rdev_q  <= req_i.dev;
      rsel_q  <= req_i.sel;
    end
    if (wr_en) begin
      port_q[wr_idx] <= rport_q;
      dev_q[wr_idx]  <= rdev_q;
      sel_q[wr_idx]  <= rsel_q;
    end
  end

endmodule

>>> rtl/ata_read_command_issue.sv
// Top level of the ATA PIO read command issue block (LBA28 / LBA48).
// Depends on acri_pkg and acri_cache.
`timescale 1ns / 1ps

// Each accepted request is handled alone; the input is stalled until its last
// word has been loaded into the output register. A request with a zero or
// oversized count gives one word, loaded from the emit state once the output
// register is free. A normal request first scans the drive select cache, one
// entry per cycle through a single compare unit, then issues its register
// writes one per cycle while the output is not stalled: up to 10 words in
// 48-bit mode, up to 6 in 28-bit mode, the drive select write only when the
// cache misses or shows a change. The mode register must only be written
// while no request is in flight.

module ata_read_command_issue #(
  parameter int unsigned CACHE_ENTRIES = acri_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic                cfg_data_i,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [15:0]         bus_port_i,
  input  logic                device_select_i,
  input  logic [47:0]         block_address_i,
  input  logic [16:0]         sector_count_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output acri_pkg::kind_e     kind_o,
  output logic [15:0]         port_addr_o,
  output logic [7:0]          write_data_o,
  output logic                last_o
);
  import acri_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LOOKUP = 3'b010,
    ST_EMIT   = 3'b100
  } state_e;

  state_e      state_q, state_d;
  step_e       step_q, step_d;
  kind_e       spec_q, spec_d;
  logic        mode_q;
  logic [15:0] port_q;
  logic        dev_q;
  logic [47:0] lba_q;
  logic [15:0] cnt_q;

  logic        out_valid_q, out_valid_d;
  kind_e       kind_q, kind_d;
  logic [15:0] paddr_q, paddr_d;
  logic [7:0]  wdata_q, wdata_d;
  logic        last_q, last_d;

  logic        accept;
  logic        is_zero;
  logic        too_big;
  logic [7:0]  sel;
  logic        slot_free;
  word_t       word;
  step_e       step_next;
  cache_req_t  creq;
  cache_rsp_t  crsp;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  // count checks against the mode limit
  assign is_zero = (sector_count_i == 17'd0);
  assign too_big = mode_q ? (sector_count_i[16] && (|sector_count_i[15:0]))
                          : ((|sector_count_i[16:9]) ||
                             (sector_count_i[8] && (|sector_count_i[7:0])));

  // drive select byte for the latched device
  assign sel = (mode_q ? SEL_LBA48 : SEL_LBA28) | {3'b000, dev_q, 4'b0000};

  // cache lookup request
  assign creq.start = accept && !is_zero && !too_big;
  assign creq.port  = bus_port_i;
  assign creq.dev   = device_select_i;
  assign creq.sel   = (mode_q ? SEL_LBA48 : SEL_LBA28) | {3'b000, device_select_i, 4'b0000};

  acri_cache #(
    .ENTRIES (CACHE_ENTRIES)
  ) u_cache (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (creq),
    .rsp_o  (crsp)
  );

  // current word and the position after it
  assign word      = acri_word(mode_q, step_q, cnt_q, lba_q, sel);
  assign step_next = (step_q == S_SELECT) ? (mode_q ? S_CNT_HI : S_CNT_LO)
                                          : step_e'(step_q + 4'd1);
  assign slot_free = !out_valid_q || !out_stall_i;

  // sequencer and output register
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    spec_d      = spec_q;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    paddr_d     = paddr_q;
    wdata_d     = wdata_q;
    last_d      = last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (is_zero) begin
            spec_d  = KIND_EMPTY;
            state_d = ST_EMIT;
          end else if (too_big) begin
            spec_d  = KIND_REJECT;
            state_d = ST_EMIT;
          end else begin
            spec_d  = KIND_WRITE;
            state_d = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP: begin
        if (crsp.done) begin
          step_d  = crsp.needed ? S_SELECT : (mode_q ? S_CNT_HI : S_CNT_LO);
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          if (spec_q != KIND_WRITE) begin
            kind_d  = spec_q;
            paddr_d = 16'h0000;
            wdata_d = 8'h00;
            last_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            kind_d  = KIND_WRITE;
            paddr_d = port_q + {13'd0, word.ofs};
            wdata_d = word.data;
            last_d  = word.last;
            step_d  = step_next;
            if (word.last) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= S_SELECT;
      spec_q      <= KIND_WRITE;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      spec_q      <= spec_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mode_q <= cfg_data_i;
      end
    end
  end

  // request capture and output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      port_q <= bus_port_i;
      dev_q  <= device_select_i;
      lba_q  <= block_address_i;
      cnt_q  <= sector_count_i[15:0];
    end
    kind_q  <= kind_d;
    paddr_q <= paddr_d;
    wdata_q <= wdata_d;
    last_q  <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign port_addr_o  = paddr_q;
  assign write_data_o = wdata_q;
  assign last_o       = last_q;

endmodule

>>> rtl/acri_checker.sv
// Port-level checker for ata_read_command_issue, attached by the bind below.
// Depends on acri_pkg for the result kinds and command opcodes.
`timescale 1ns / 1ps

module acri_port_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input acri_pkg::kind_e kind_o,
  input logic [15:0]     port_addr_o,
  input logic [7:0]      write_data_o,
  input logic            last_o
);
  import acri_pkg::*;

  // a request makes the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while block stays ready");

  // empty and rejected answers are single words
  a_spec_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o != KIND_WRITE)) |-> last_o)
    else $error("special answer not marked last");

  // the last register write is the command opcode
  a_last_is_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == KIND_WRITE) && last_o) |->
      ((write_data_o == CMD_READ) || (write_data_o == CMD_READ_EXT)))
    else $error("last write is not a read command");

  // no new request while a sequence is still mid-way
  a_busy_mid_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> in_stall_o)
    else $error("request taken before sequence end");

  // a stalled word holds
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(port_addr_o) && $stable(write_data_o) && $stable(last_o)))
    else $error("stalled word changed");

endmodule

bind ata_read_command_issue acri_port_checker u_acri_checker (.*);
